>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising clk edge; skip while rst_n is low.
`define SIQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop on every rising clk edge, reset included.
`define SIQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/siq_pkg.sv
// ----------------------------------------------------------------------------
// siq_pkg
// Types and codes shared by the skin influence quantizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package siq_pkg;

	localparam int SLOTS = 4;

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_JOINT_COUNT = 1'b1;

	localparam logic [2:0] STAT_OK           = 3'd0;
	localparam logic [2:0] STAT_ZERO_WEIGHT  = 3'd1;
	localparam logic [2:0] STAT_BAD_POINT    = 3'd2;
	localparam logic [2:0] STAT_BAD_JOINT    = 3'd3;
	localparam logic [2:0] STAT_NO_INFLUENCE = 3'd4;

	typedef struct packed {
		logic        command;
		logic [11:0] point_index;
		logic [15:0] joint_index;
		logic [15:0] weight;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] joint_0;
		logic [15:0] joint_1;
		logic [15:0] joint_2;
		logic [15:0] joint_3;
		logic [7:0]  qweight_0;
		logic [7:0]  qweight_1;
		logic [7:0]  qweight_2;
		logic [7:0]  qweight_3;
	} rsp_t;

	// classified request, as it waits between front and back
	typedef struct packed {
		logic        command;
		logic [11:0] point;
		logic [15:0] joint;
		logic [15:0] weight;
		logic [2:0]  status;
	} qent_t;

	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qport_t;

endpackage

`default_nettype wire

>>> src/skin_influence_top4_quantizer.sv
// ----------------------------------------------------------------------------
// skin_influence_top4_quantizer
// Per-point top-four joint influence table with 8-bit weight quantization.
// ----------------------------------------------------------------------------
//
//   channel  handshake              payload
//   req      req_valid / req_stall  req_data  (command, point, joint, weight)
//   rsp      rsp_valid / rsp_stall  rsp_data  (status, joints, qweights)
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// After reset the table is swept to zero, one entry per cycle; requests stall
// during the sweep, configuration writes still land. A rejected request goes
// straight to report, a push through update and report, a finish through
// table read, sort, weight sum, 8 shared restoring-divider steps and report.
// The front queue holds two requests, so the sender keeps going while the
// back works; the response register lets the back move on once a result
// is loaded, and a stalled response holds the back in its report state.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_influence_top4_quantizer #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire siq_pkg::req_t  req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output siq_pkg::rsp_t       rsp_data,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic           cfg_index,
	input  wire logic [15:0]    cfg_data
);

	siq_pkg::qport_t head;
	logic            pop;
	logic            clearing;

	// registers accept a write on any cycle
	assign cfg_ready = 1'b1;

	// check and queue each request
	siq_front #(
		.MAX_POINTS (MAX_POINTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.hold      (clearing),
		.pop       (pop),
		.head      (head)
	);

	// update, sort and quantize against the slot table
	siq_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.clearing  (clearing),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

>>> src/siq_front.sv
// ----------------------------------------------------------------------------
// siq_front
// Holds the configuration, range-checks each request, flags a zero-weight push and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module siq_front #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_valid,
	input  wire logic            cfg_index,
	input  wire logic [15:0]     cfg_data,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire siq_pkg::req_t   req_data,
	input  wire logic            hold,
	input  wire logic            pop,
	output siq_pkg::qport_t      head
);

	logic [12:0]     point_count_q;
	logic [15:0]     joint_count_q;
	siq_pkg::qent_t  ent_q [2];
	logic            wp_q;
	logic            rp_q;
	logic [1:0]      cnt_q;
	siq_pkg::qent_t  cls;
	logic            pt_ok;
	logic            push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			joint_count_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				siq_pkg::CFG_POINT_COUNT: point_count_q <= cfg_data[12:0];
				siq_pkg::CFG_JOINT_COUNT: joint_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pt_ok = ({1'b0, req_data.point_index} < point_count_q) &&
			(32'(req_data.point_index) < 32'(MAX_POINTS));
		cls.command = req_data.command;
		cls.point   = req_data.point_index;
		cls.joint   = req_data.joint_index;
		cls.weight  = req_data.weight;
		cls.status  = siq_pkg::STAT_OK;
		if (req_data.command == siq_pkg::CMD_PUSH) begin
			if (req_data.joint_index >= joint_count_q) begin
				cls.status = siq_pkg::STAT_BAD_JOINT;
			end else if (!pt_ok) begin
				cls.status = siq_pkg::STAT_BAD_POINT;
			end else if (req_data.weight == 16'd0) begin
				cls.status = siq_pkg::STAT_ZERO_WEIGHT;
			end
		end else if (!pt_ok) begin
			cls.status = siq_pkg::STAT_BAD_POINT;
		end
	end

	assign req_stall = hold || (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	assign head.valid = (cnt_q != 2'd0);
	assign head.ent   = ent_q[rp_q];

endmodule

`default_nettype wire

>>> src/siq_back.sv
// ----------------------------------------------------------------------------
// siq_back
// Owns the slot table: clears it, updates slots, sorts and quantizes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module siq_back #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire siq_pkg::qport_t  head,
	output logic                  pop,
	output logic                  clearing,
	input  wire logic             rsp_stall,
	output logic                  rsp_valid,
	output siq_pkg::rsp_t         rsp_data
);

	localparam int AW = $clog2(MAX_POINTS);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_CALC = 6'b000100,
		S_SUM  = 6'b001000,
		S_DIV  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t          st_q;
	logic [AW-1:0]   clr_addr_q;
	logic [2:0]      cnt_q;
	logic            rsp_valid_q;
	siq_pkg::rsp_t   rsp_q;
	siq_pkg::rsp_t   res_q;
	siq_pkg::qent_t  cur_q;
	logic [127:0]    mem [MAX_POINTS];
	logic [127:0]    rd_q;
	logic [15:0]     srt_w_q [4];
	logic [15:0]     srt_j_q [4];
	logic [18:0]     d_q;
	logic [25:0]     r_q [4];
	logic [7:0]      q_q [4];

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [127:0]    mem_wdata;
	logic [15:0]     w [4];
	logic [15:0]     j [4];
	logic [15:0]     sw [4];
	logic [15:0]     sj [4];
	logic [15:0]     tw;
	logic [15:0]     tj;
	logic [1:0]      mi;
	logic [15:0]     mw;
	logic            take;
	logic [127:0]    push_word;
	logic [127:0]    sort_word;
	logic [17:0]     sum;
	logic [25:0]     rn [4];
	logic [7:0]      qn [4];
	logic [25:0]     dsh;
	logic            load;
	logic            rem_ok;

	// slot lanes of the word read for the current request
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			w[k] = rd_q[16*k +: 16];
			j[k] = rd_q[64 + 16*k +: 16];
		end
	end

	// weakest slot, lowest slot on ties
	always_comb begin
		mi = 2'd0;
		mw = w[0];
		for (int k = 1; k < 4; k++) begin
			if (w[k] < mw) begin
				mw = w[k];
				mi = 2'(k);
			end
		end
		take = (cur_q.weight > mw);
		push_word = rd_q;
		push_word[16*mi +: 16]      = cur_q.weight;
		push_word[64 + 16*mi +: 16] = cur_q.joint;
	end

	// exchange sort, descending, swap on strictly smaller
	always_comb begin
		tw = '0;
		tj = '0;
		for (int k = 0; k < 4; k++) begin
			sw[k] = w[k];
			sj[k] = j[k];
		end
		for (int a = 0; a < 3; a++) begin
			for (int b = a + 1; b < 4; b++) begin
				if (sw[a] < sw[b]) begin
					tw = sw[a]; sw[a] = sw[b]; sw[b] = tw;
					tj = sj[a]; sj[a] = sj[b]; sj[b] = tj;
				end
			end
		end
		for (int k = 0; k < 4; k++) begin
			sort_word[16*k +: 16]      = sw[k];
			sort_word[64 + 16*k +: 16] = sj[k];
		end
	end

	assign sum = 18'(srt_w_q[0]) + 18'(srt_w_q[1]) + 18'(srt_w_q[2]) + 18'(srt_w_q[3]);

	// one quotient bit per lane per cycle, shared divisor
	always_comb begin
		dsh = 26'(d_q) << cnt_q;
		for (int k = 0; k < 4; k++) begin
			if (r_q[k] >= dsh) begin
				rn[k] = r_q[k] - dsh;
				qn[k] = {q_q[k][6:0], 1'b1};
			end else begin
				rn[k] = r_q[k];
				qn[k] = {q_q[k][6:0], 1'b0};
			end
		end
	end

	assign rem_ok = (r_q[0] < 26'(d_q)) && (r_q[1] < 26'(d_q)) &&
		(r_q[2] < 26'(d_q)) && (r_q[3] < 26'(d_q));

	assign pop      = (st_q == S_IDLE) && head.valid;
	assign clearing = (st_q == S_CLR);
	assign load     = (st_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(cur_q.point);
		mem_wdata = push_word;
		if (st_q == S_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else if (st_q == S_CALC) begin
			if (cur_q.command == siq_pkg::CMD_FINISH) begin
				mem_we    = 1'b1;
				mem_wdata = sort_word;
			end else begin
				mem_we = take;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[AW'(head.ent.point)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLR;
			clr_addr_q  <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(MAX_POINTS - 1)) begin
						st_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (head.valid) begin
						st_q <= (head.ent.status != siq_pkg::STAT_OK) ? S_OUT : S_CALC;
					end
				end
				S_CALC: begin
					if (cur_q.command == siq_pkg::CMD_FINISH && sw[0] != 16'd0) begin
						st_q <= S_SUM;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_SUM: begin
					cnt_q <= 3'd7;
					st_q  <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == 3'd0) begin
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.ent;
			res_q <= siq_pkg::rsp_t'({head.ent.status, 96'd0});
		end
		if (st_q == S_CALC) begin
			for (int k = 0; k < 4; k++) begin
				srt_w_q[k] <= sw[k];
				srt_j_q[k] <= sj[k];
			end
			if (cur_q.command == siq_pkg::CMD_FINISH && sw[0] == 16'd0) begin
				res_q.status <= siq_pkg::STAT_NO_INFLUENCE;
			end
		end
		if (st_q == S_SUM) begin
			d_q <= {sum, 1'b0};
			for (int k = 0; k < 4; k++) begin
				r_q[k] <= ({srt_w_q[k], 9'b0} - {9'b0, srt_w_q[k], 1'b0}) + 26'(sum);
				q_q[k] <= '0;
			end
		end
		if (st_q == S_DIV) begin
			for (int k = 0; k < 4; k++) begin
				r_q[k] <= rn[k];
				q_q[k] <= qn[k];
			end
			if (cnt_q == 3'd0) begin
				res_q.status    <= siq_pkg::STAT_OK;
				res_q.joint_0   <= srt_j_q[0];
				res_q.joint_1   <= srt_j_q[1];
				res_q.joint_2   <= srt_j_q[2];
				res_q.joint_3   <= srt_j_q[3];
				res_q.qweight_0 <= qn[0];
				res_q.qweight_1 <= qn[1];
				res_q.qweight_2 <= qn[2];
				res_q.qweight_3 <= qn[3];
			end
		end
		if (load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`SIQ_ASSERT(a_div_rem, clk, arst_n, (st_q == S_DIV && cnt_q == 3'd0) |=> rem_ok, "divider remainder not below divisor")
	`SIQ_ASSERT(a_rsp_src, clk, arst_n, $rose(rsp_valid_q) |-> $past(st_q) == S_OUT, "response raised outside output state")
	`SIQ_ASSERT_ALWAYS(a_no_wr, clk, (st_q == S_SUM || st_q == S_DIV || st_q == S_OUT) |-> !mem_we, "table written while quantizing or reporting")

endmodule

`default_nettype wire

>>> bench/skin_influence_top4_quantizer_tb.sv
// ----------------------------------------------------------------------------
// skin_influence_top4_quantizer_tb
// Self-checking bench: drives push and finish requests under random bursts and
// response stalls, predicts every response from a private copy of the
// influence table, and compares each response field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module skin_influence_top4_quantizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXP = 4096;

	// Influence table model and response checker.
	class influence_board;
		logic [15:0] joints [MAXP][siq_pkg::SLOTS];
		logic [15:0] weights [MAXP][siq_pkg::SLOTS];
		int unsigned point_limit;
		int unsigned joint_limit;
		siq_pkg::rsp_t pending [$];
		int errors;

		function void clear();
			for (int p = 0; p < MAXP; p++)
				for (int s = 0; s < siq_pkg::SLOTS; s++) begin
					joints[p][s] = '0;
					weights[p][s] = '0;
				end
			point_limit = 0;
			joint_limit = 0;
			errors = 0;
		endfunction

		function void note_request(siq_pkg::req_t r);
			siq_pkg::rsp_t e;
			int unsigned lim, mi, mw, sum, q;
			logic [15:0] t;
			e = '0;
			lim = (point_limit > MAXP) ? MAXP : point_limit;
			if (r.command == siq_pkg::CMD_PUSH) begin
				if (r.joint_index >= joint_limit)
					e.status = siq_pkg::STAT_BAD_JOINT;
				else if (r.point_index >= lim)
					e.status = siq_pkg::STAT_BAD_POINT;
				else if (r.weight == 0)
					e.status = siq_pkg::STAT_ZERO_WEIGHT;
				else begin
					mi = 0;
					mw = weights[r.point_index][0];
					for (int s = 1; s < siq_pkg::SLOTS; s++)
						if (weights[r.point_index][s] < mw) begin
							mw = weights[r.point_index][s];
							mi = s;
						end
					// replace the weakest slot only on a strictly larger weight
					if (r.weight > mw) begin
						weights[r.point_index][mi] = r.weight;
						joints[r.point_index][mi] = r.joint_index;
					end
					e.status = siq_pkg::STAT_OK;
				end
			end else if (r.point_index >= lim)
				e.status = siq_pkg::STAT_BAD_POINT;
			else begin
				// exchange sort, descending, written back into the table
				for (int i = 0; i < siq_pkg::SLOTS; i++)
					for (int k = i + 1; k < siq_pkg::SLOTS; k++)
						if (weights[r.point_index][i] < weights[r.point_index][k]) begin
							t = weights[r.point_index][i];
							weights[r.point_index][i] = weights[r.point_index][k];
							weights[r.point_index][k] = t;
							t = joints[r.point_index][i];
							joints[r.point_index][i] = joints[r.point_index][k];
							joints[r.point_index][k] = t;
						end
				if (weights[r.point_index][0] == 0)
					e.status = siq_pkg::STAT_NO_INFLUENCE;
				else begin
					sum = 0;
					for (int s = 0; s < siq_pkg::SLOTS; s++)
						sum += weights[r.point_index][s];
					e.status = siq_pkg::STAT_OK;
					e.joint_0 = joints[r.point_index][0];
					e.joint_1 = joints[r.point_index][1];
					e.joint_2 = joints[r.point_index][2];
					e.joint_3 = joints[r.point_index][3];
					for (int s = 0; s < siq_pkg::SLOTS; s++) begin
						q = (weights[r.point_index][s] * 510 + sum) / (2 * sum);
						if (q > 255)
							q = 255;
						case (s)
							0: e.qweight_0 = q[7:0];
							1: e.qweight_1 = q[7:0];
							2: e.qweight_2 = q[7:0];
							default: e.qweight_3 = q[7:0];
						endcase
					end
				end
			end
			pending.push_back(e);
		endfunction

		function void check_response(siq_pkg::rsp_t a);
			siq_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$error("response with nothing expected: %h", a);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.status !== e.status) begin
				$error("status expected %0d got %0d", e.status, a.status); errors++;
			end
			if (a.joint_0 !== e.joint_0) begin
				$error("joint_0 expected %0d got %0d", e.joint_0, a.joint_0); errors++;
			end
			if (a.joint_1 !== e.joint_1) begin
				$error("joint_1 expected %0d got %0d", e.joint_1, a.joint_1); errors++;
			end
			if (a.joint_2 !== e.joint_2) begin
				$error("joint_2 expected %0d got %0d", e.joint_2, a.joint_2); errors++;
			end
			if (a.joint_3 !== e.joint_3) begin
				$error("joint_3 expected %0d got %0d", e.joint_3, a.joint_3); errors++;
			end
			if (a.qweight_0 !== e.qweight_0) begin
				$error("qweight_0 expected %0d got %0d", e.qweight_0, a.qweight_0); errors++;
			end
			if (a.qweight_1 !== e.qweight_1) begin
				$error("qweight_1 expected %0d got %0d", e.qweight_1, a.qweight_1); errors++;
			end
			if (a.qweight_2 !== e.qweight_2) begin
				$error("qweight_2 expected %0d got %0d", e.qweight_2, a.qweight_2); errors++;
			end
			if (a.qweight_3 !== e.qweight_3) begin
				$error("qweight_3 expected %0d got %0d", e.qweight_3, a.qweight_3); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	siq_pkg::req_t req_data = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	siq_pkg::rsp_t rsp_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	influence_board board;
	bit stall_enable = 1'b0;
	int burst_left = 0;

	always #6 clk = ~clk;

	skin_influence_top4_quantizer #(.MAX_POINTS(MAXP)) dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Check every accepted response; the predictor runs when a request is taken.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			board.check_response(rsp_data);
	end

	// Receiver stall pattern: calm stretches alternate with heavy stalling.
	always @(posedge clk) begin
		if (!stall_enable)
			rsp_stall <= 1'b0;
		else if (($urandom % 64) < 8)
			rsp_stall <= 1'b0;
		else
			rsp_stall <= (($urandom % 4) == 0) ? 1'b1 : rsp_stall & (($urandom % 3) != 0);
	end

	// Write one configuration register while the block is idle.
	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == siq_pkg::CFG_POINT_COUNT)
			board.point_limit = val[12:0];
		else
			board.joint_limit = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Send one request, inserting a random gap between bursts.
	task automatic send_request(input siq_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom % 3 == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (req_stall);
		board.note_request(r);
	endtask

	// Drop valid, wait for all responses and the tail of a finish.
	task automatic drain();
		req_valid <= 1'b0;
		burst_left = 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic siq_pkg::req_t make_req(logic cmd, logic [11:0] p, logic [15:0] j,
			logic [15:0] w);
		siq_pkg::req_t r;
		r.command = cmd;
		r.point_index = p;
		r.joint_index = j;
		r.weight = w;
		return r;
	endfunction

	// Mostly well-formed traffic on a few points, some noise and edge values.
	task automatic random_phase(input int count, input int unsigned pts);
		siq_pkg::req_t r;
		int unsigned lim;
		for (int n = 0; n < count; n++) begin
			lim = (board.point_limit > MAXP) ? MAXP : board.point_limit;
			r = make_req(($urandom % 5) == 0 ? siq_pkg::CMD_FINISH : siq_pkg::CMD_PUSH,
				lim == 0 ? 12'($urandom) : 12'($urandom_range(0, pts - 1)),
				board.joint_limit == 0 ? 16'($urandom) :
					16'($urandom_range(0, board.joint_limit - 1)),
				16'($urandom_range(1, 65535)));
			case ($urandom % 16)
				0: r.point_index = 12'($urandom);
				1: r.joint_index = 16'($urandom_range(0, 65534));
				2: r.weight = '0;
				3: r.weight = 16'($urandom_range(1, 4));
				4: r.weight = 16'hFFFF;
				default: ;
			endcase
			send_request(r);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Everything out of range with reset configuration.
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd0, 16'd0, 16'd1));
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd0, 16'd0, 16'd0));
		drain();

		write_reg(siq_pkg::CFG_POINT_COUNT, 16'd4096);
		write_reg(siq_pkg::CFG_JOINT_COUNT, 16'd65535);
		// Directed: error ordering, weak push, ties, empty slots, extremes.
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd4095, 16'd0, 16'd0));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd4095, 16'hFFFF, 16'd0));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd4095, 16'hFFFE, 16'd0));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd4095, 16'hFFFE, 16'hFFFF));
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd4095, 16'hFFFF, 16'hFFFF));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd11, 16'd100));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd12, 16'd100));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd13, 16'd100));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd14, 16'd100));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd15, 16'd100));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd16, 16'd1));
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd7, 16'd0, 16'd0));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd7, 16'd0, 16'd65535));
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd7, 16'd0, 16'd0));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd0, 16'd1, 16'd3));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd0, 16'd2, 16'd1));
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd0, 16'd0, 16'd0));
		drain();

		write_reg(siq_pkg::CFG_POINT_COUNT, 16'd8);
		write_reg(siq_pkg::CFG_JOINT_COUNT, 16'd1);
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd8, 16'd1, 16'd0));
		send_request(make_req(siq_pkg::CMD_PUSH, 12'd8, 16'd0, 16'd0));
		send_request(make_req(siq_pkg::CMD_FINISH, 12'd8, 16'd0, 16'd0));
		random_phase(150, 8);
		drain();

		stall_enable = 1'b1;
		write_reg(siq_pkg::CFG_JOINT_COUNT, 16'd40);
		random_phase(600, 8);
		drain();

		write_reg(siq_pkg::CFG_POINT_COUNT, 16'h1FFF);
		write_reg(siq_pkg::CFG_JOINT_COUNT, 16'd65535);
		random_phase(500, 16);
		drain();

		stall_enable = 1'b0;
		write_reg(siq_pkg::CFG_POINT_COUNT, 16'd4096);
		write_reg(siq_pkg::CFG_JOINT_COUNT, 16'd300);
		random_phase(300, 4096);
		drain();

		stall_enable = 1'b1;
		write_reg(siq_pkg::CFG_POINT_COUNT, 16'd3);
		random_phase(400, 4);
		drain();

		if (board.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Generous watchdog, well above the slowest correct run.
	initial begin
		#40ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
